// ===== rtl/core/string_key_value_table_unit_assert.svh =====
// assertion macros for the key/value table unit
// no dependencies
`ifndef STRING_KEY_VALUE_TABLE_UNIT_ASSERT_SVH
`define STRING_KEY_VALUE_TABLE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SKV_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define SKV_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define SKV_ASSERT_IMP(label, clk, rst_n, a, b)
`define SKV_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/core/skv_pkg.sv =====
// shared types and constants of the key/value table unit
// no dependencies
`default_nettype none
package skv_pkg;
    localparam int ENTRIES = 128;
    localparam int KEY_BYTES = 31;
    localparam int VALUE_BYTES = 63;
    localparam int COMMAND_BYTES = 256;
    localparam int EW = $clog2(ENTRIES);
    localparam int KLW = $clog2(KEY_BYTES + 1);
    localparam int KIW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int VLW = $clog2(VALUE_BYTES + 1);
    localparam int VIW = (VALUE_BYTES > 1) ? $clog2(VALUE_BYTES) : 1;
    localparam int PW = $clog2(COMMAND_BYTES + 1);
    localparam int QD = 4;
    localparam int QW = $clog2(QD);

    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

    typedef enum logic [8:0] {
        PH_P = 9'b000000001, PH_U = 9'b000000010, PH_T = 9'b000000100,
        PH_SP = 9'b000001000, PH_KEY = 9'b000010000, PH_SKIP = 9'b000100000,
        PH_VALUE = 9'b001000000, PH_DONE = 9'b010000000, PH_FAIL = 9'b100000000
    } phase_t;

    // command from front to back
    typedef struct packed {
        logic is_get;
        logic ok;        // put: well formed; get: key valid
        logic buf_sel;   // which pending buffer bank holds the text
        logic [KLW-1:0] klen;
        logic [VLW-1:0] vlen;
    } cmd_t;

    function automatic logic is_white(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/skv_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module skv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/skv_front.sv =====
// front part: parses command, key and value bytes into pending buffers
// depends on skv_pkg, skv_ram
`default_nettype none
module skv_front (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire logic op,
    input  wire logic [7:0] data_byte,
    input  wire logic last_byte,
    output logic      cmd_valid,
    output skv_pkg::cmd_t cmd,
    input  wire logic q_full,
    input  wire logic buf_busy,      // back still owns the bank we would write
    input  wire logic rd_sel,
    input  wire logic [skv_pkg::KIW-1:0] kraddr,
    output logic [7:0] krdata,
    input  wire logic [skv_pkg::VIW-1:0] vraddr,
    output logic [7:0] vrdata
);
    logic busy_reg, cur_op_reg, key_over_reg, key_ended_reg, bank_reg;
    skv_pkg::phase_t ph_reg;
    logic [skv_pkg::PW-1:0] pos_reg;
    logic [skv_pkg::KLW-1:0] pk_reg;
    logic [skv_pkg::VLW-1:0] pv_reg;

    logic fire, fresh;
    logic [7:0] c;
    skv_pkg::phase_t ph, ph_n;
    logic [skv_pkg::PW-1:0] pos;
    logic [skv_pkg::KLW-1:0] pk, pk_n;
    logic [skv_pkg::VLW-1:0] pv, pv_n;
    logic ko, ke, ko_n, ke_n;
    logic kwe, vwe;
    logic [skv_pkg::KIW-1:0] kwa;
    logic [skv_pkg::VIW-1:0] vwa;
    logic [7:0] kr0, kr1, vr0, vr1;

    // two banks so the back can search one while the next text fills the other
    assign in_ready = !q_full && !buf_busy;
    assign fire = in_valid && in_ready;

    always_comb
    begin
        fresh = !busy_reg || (op != cur_op_reg);
        ph = fresh ? skv_pkg::PH_P : ph_reg;
        pos = fresh ? '0 : pos_reg;
        pk = fresh ? '0 : pk_reg;
        pv = fresh ? '0 : pv_reg;
        ko = fresh ? 1'b0 : key_over_reg;
        ke = fresh ? 1'b0 : key_ended_reg;
        c = (pos >= skv_pkg::PW'(skv_pkg::COMMAND_BYTES - 1)) ? 8'h00 : data_byte;
        ph_n = ph; pk_n = pk; pv_n = pv; ko_n = ko; ke_n = ke;
        kwe = 1'b0; vwe = 1'b0;
        kwa = pk[skv_pkg::KIW-1:0];
        vwa = pv[skv_pkg::VIW-1:0];
        if (op == skv_pkg::OP_PUT)
        begin
            case (ph)
                skv_pkg::PH_P:  ph_n = (c == 8'h50) ? skv_pkg::PH_U : skv_pkg::PH_FAIL;
                skv_pkg::PH_U:  ph_n = (c == 8'h55) ? skv_pkg::PH_T : skv_pkg::PH_FAIL;
                skv_pkg::PH_T:  ph_n = (c == 8'h54) ? skv_pkg::PH_SP : skv_pkg::PH_FAIL;
                skv_pkg::PH_SP: ph_n = (c == 8'h20) ? skv_pkg::PH_KEY : skv_pkg::PH_FAIL;
                skv_pkg::PH_KEY:
                begin
                    if (c == 8'h00) ph_n = skv_pkg::PH_FAIL;
                    else if (c == 8'h3A)
                        ph_n = (pk != '0) ? skv_pkg::PH_SKIP : skv_pkg::PH_FAIL;
                    else if (pk >= skv_pkg::KLW'(skv_pkg::KEY_BYTES))
                        ph_n = skv_pkg::PH_FAIL;
                    else
                    begin
                        kwe = 1'b1;
                        pk_n = pk + 1'b1;
                    end
                end
                skv_pkg::PH_SKIP:
                begin
                    if (c == 8'h00) ph_n = skv_pkg::PH_FAIL;
                    else if (!skv_pkg::is_white(c))
                    begin
                        vwe = 1'b1;
                        vwa = '0;
                        pv_n = skv_pkg::VLW'(1);
                        ph_n = (skv_pkg::VALUE_BYTES <= 1) ? skv_pkg::PH_DONE
                                                           : skv_pkg::PH_VALUE;
                    end
                end
                skv_pkg::PH_VALUE:
                begin
                    if (c == 8'h00 || skv_pkg::is_white(c)) ph_n = skv_pkg::PH_DONE;
                    else
                    begin
                        vwe = 1'b1;
                        pv_n = pv + 1'b1;
                        if (pv_n >= skv_pkg::VLW'(skv_pkg::VALUE_BYTES))
                            ph_n = skv_pkg::PH_DONE;
                    end
                end
                default: ;
            endcase
        end
        else if (!ke)
        begin
            if (c == 8'h00) ke_n = 1'b1;
            else if (pk < skv_pkg::KLW'(skv_pkg::KEY_BYTES))
            begin
                kwe = 1'b1;
                pk_n = pk + 1'b1;
            end
            else ko_n = 1'b1;
        end
        kwe = kwe && fire;
        vwe = vwe && fire;
    end

    assign cmd_valid = fire && last_byte;
    always_comb
    begin
        cmd.is_get = op;
        cmd.buf_sel = bank_reg;
        cmd.klen = pk_n;
        cmd.vlen = pv_n;
        cmd.ok = (op == skv_pkg::OP_GET) ? (!ko_n && pk_n != '0)
               : (ph_n == skv_pkg::PH_VALUE || ph_n == skv_pkg::PH_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0; cur_op_reg <= 1'b0; bank_reg <= 1'b0;
            ph_reg <= skv_pkg::PH_P; pos_reg <= '0; pk_reg <= '0; pv_reg <= '0;
            key_over_reg <= 1'b0; key_ended_reg <= 1'b0;
        end
        else if (fire)
        begin
            busy_reg <= !last_byte;
            cur_op_reg <= op;
            ph_reg <= last_byte ? skv_pkg::PH_P : ph_n;
            pos_reg <= (pos < skv_pkg::PW'(skv_pkg::COMMAND_BYTES)) ? pos + 1'b1 : pos;
            pk_reg <= pk_n; pv_reg <= pv_n;
            key_over_reg <= ko_n; key_ended_reg <= ke_n;
            if (last_byte) bank_reg <= !bank_reg;
        end
    end

    skv_ram #(.WIDTH(8), .DEPTH(skv_pkg::KEY_BYTES)) u_k0 (.clk(clk),
        .we(kwe && !bank_reg), .waddr(kwa), .wdata(c), .raddr(kraddr), .rdata(kr0));
    skv_ram #(.WIDTH(8), .DEPTH(skv_pkg::KEY_BYTES)) u_k1 (.clk(clk),
        .we(kwe && bank_reg), .waddr(kwa), .wdata(c), .raddr(kraddr), .rdata(kr1));
    skv_ram #(.WIDTH(8), .DEPTH(skv_pkg::VALUE_BYTES)) u_v0 (.clk(clk),
        .we(vwe && !bank_reg), .waddr(vwa), .wdata(c), .raddr(vraddr), .rdata(vr0));
    skv_ram #(.WIDTH(8), .DEPTH(skv_pkg::VALUE_BYTES)) u_v1 (.clk(clk),
        .we(vwe && bank_reg), .waddr(vwa), .wdata(c), .raddr(vraddr), .rdata(vr1));
    assign krdata = rd_sel ? kr1 : kr0;
    assign vrdata = rd_sel ? vr1 : vr0;
endmodule
`default_nettype wire

// ===== rtl/core/skv_queue.sv =====
// short command queue between front and back
// depends on skv_pkg
`default_nettype none
`include "string_key_value_table_unit_assert.svh"
module skv_queue (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire skv_pkg::cmd_t din,
    input  wire logic pop,
    output logic      not_empty,
    output logic      full,
    output logic [skv_pkg::QW:0] count,
    output skv_pkg::cmd_t dout
);
    skv_pkg::cmd_t q_reg [skv_pkg::QD];
    logic [skv_pkg::QW-1:0] wp_reg, rp_reg;
    logic [skv_pkg::QW:0] cnt_reg;
    assign not_empty = cnt_reg != '0;
    assign full = cnt_reg == (skv_pkg::QW+1)'(skv_pkg::QD);
    assign count = cnt_reg;
    assign dout = q_reg[rp_reg];
    always_ff @(posedge clk)
    begin
        if (push) q_reg[wp_reg] <= din;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (skv_pkg::QW+1)'(push) - (skv_pkg::QW+1)'(pop);
        end
    end
    `SKV_ASSERT_IMP(a_no_overflow, clk, rst_n, full, !push)
    `SKV_ASSERT_IMP(a_no_underflow, clk, rst_n, !not_empty, !pop)
    `SKV_ASSERT_NXT(a_push_counts, clk, rst_n, push && !pop, cnt_reg != '0)
endmodule
`default_nettype wire

// ===== rtl/core/skv_back.sv =====
// back part: table search, commit and lookup answer
// depends on skv_pkg, skv_ram
`default_nettype none
`include "string_key_value_table_unit_assert.svh"
module skv_back (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    input  wire skv_pkg::cmd_t cmd,
    output logic      cmd_pop,
    output logic      rd_sel,
    output logic [skv_pkg::KIW-1:0] kraddr,
    input  wire logic [7:0] krdata,
    output logic [skv_pkg::VIW-1:0] vraddr,
    input  wire logic [7:0] vrdata,
    output logic      out_valid,
    input  wire logic out_ready,
    output logic [8:0] out_data,   // found, value_byte
    output logic      out_last
);
    localparam int KAW = $clog2(skv_pkg::ENTRIES * skv_pkg::KEY_BYTES);
    localparam int VAW = $clog2(skv_pkg::ENTRIES * skv_pkg::VALUE_BYTES);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001, S_ENT = 8'b00000010, S_CMP = 8'b00000100,
        S_DEC = 8'b00001000, S_KCP = 8'b00010000, S_VCP = 8'b00100000,
        S_OUT = 8'b01000000, S_MISS = 8'b10000000
    } st_t;

    st_t st_reg, st_next;
    logic [skv_pkg::ENTRIES-1:0] used_reg;
    logic [skv_pkg::EW-1:0] ent_reg, free_reg;
    logic have_free_reg, match_reg, eq_reg;
    logic [skv_pkg::VLW:0] k_reg;    // byte index with lag stage
    logic [skv_pkg::VLW:0] n_reg;
    logic [skv_pkg::KLW-1:0] klen_rd, klen_w;
    logic [skv_pkg::VLW-1:0] vlen_rd;
    logic [7:0] kt_rd, vt_rd;
    logic kt_we, vt_we, kl_we, vl_we;
    logic [KAW-1:0] kt_wa, kt_ra;
    logic [VAW-1:0] vt_wa, vt_ra;
    logic [skv_pkg::EW-1:0] lat_ent;
    logic obuf_full_reg;
    logic [8:0] odata_reg;
    logic olast_reg;
    logic emit;
    logic [8:0] emit_data;
    logic emit_last;
    logic [skv_pkg::KIW-1:0] kidx;
    logic [skv_pkg::VIW-1:0] vidx;
    logic [skv_pkg::VIW-1:0] vt_idx;
    logic eq_now;

    assign rd_sel = cmd.buf_sel;
    assign kidx = k_reg[skv_pkg::KIW-1:0];
    assign vidx = k_reg[skv_pkg::VIW-1:0];
    assign kraddr = kidx;
    assign vraddr = vidx;
    assign kt_ra = KAW'(ent_reg) * KAW'(skv_pkg::KEY_BYTES) + KAW'(kidx);
    assign vt_ra = VAW'(ent_reg) * VAW'(skv_pkg::VALUE_BYTES) + VAW'(vt_idx);
    assign lat_ent = match_reg ? ent_reg : free_reg;

    // write side uses the previous index, as the registered read data lags the read index
    logic [skv_pkg::VLW:0] kp;
    assign kp = k_reg - 1'b1;
    assign kt_wa = KAW'(lat_ent) * KAW'(skv_pkg::KEY_BYTES)
                 + KAW'(kp[skv_pkg::KIW-1:0]);
    assign vt_wa = VAW'(lat_ent) * VAW'(skv_pkg::VALUE_BYTES)
                 + VAW'(kp[skv_pkg::VIW-1:0]);
    // a stalled answer keeps reading the byte it is holding
    assign vt_idx = (st_reg == S_OUT && k_reg != '0 && !emit) ? kp[skv_pkg::VIW-1:0] : vidx;
    // compare result including the byte that arrives this cycle
    assign eq_now = eq_reg && (k_reg == '0 || kt_rd == krdata);
    assign kt_we = st_reg == S_KCP && k_reg != '0;
    assign vt_we = st_reg == S_VCP && k_reg != '0;
    assign kl_we = st_reg == S_DEC && cmd_valid && !cmd.is_get && !match_reg && have_free_reg;
    assign vl_we = kl_we || (st_reg == S_DEC && cmd_valid && !cmd.is_get && match_reg);
    assign klen_w = cmd.klen;

    skv_ram #(.WIDTH(8), .DEPTH(skv_pkg::ENTRIES * skv_pkg::KEY_BYTES)) u_kt (.clk(clk),
        .we(kt_we), .waddr(kt_wa), .wdata(krdata), .raddr(kt_ra), .rdata(kt_rd));
    skv_ram #(.WIDTH(8), .DEPTH(skv_pkg::ENTRIES * skv_pkg::VALUE_BYTES)) u_vt (.clk(clk),
        .we(vt_we), .waddr(vt_wa), .wdata(vrdata), .raddr(vt_ra), .rdata(vt_rd));
    skv_ram #(.WIDTH(skv_pkg::KLW), .DEPTH(skv_pkg::ENTRIES)) u_kl (.clk(clk),
        .we(kl_we), .waddr(lat_ent), .wdata(klen_w), .raddr(ent_reg), .rdata(klen_rd));
    skv_ram #(.WIDTH(skv_pkg::VLW), .DEPTH(skv_pkg::ENTRIES)) u_vl (.clk(clk),
        .we(vl_we), .waddr(lat_ent), .wdata(cmd.vlen), .raddr(ent_reg), .rdata(vlen_rd));

    assign out_valid = obuf_full_reg;
    assign out_data = odata_reg;
    assign out_last = olast_reg;

    logic last_ent;
    assign last_ent = ent_reg == skv_pkg::EW'(skv_pkg::ENTRIES - 1);

    always_comb
    begin
        st_next = st_reg;
        cmd_pop = 1'b0;
        emit = 1'b0;
        emit_data = '0;
        emit_last = 1'b1;
        case (st_reg)
            S_IDLE: if (cmd_valid)
                begin
                    if (cmd.is_get && !cmd.ok)
                        st_next = S_MISS;
                    else if (!cmd.ok)
                        cmd_pop = 1'b1;
                    else
                        st_next = S_ENT;
                end
            // entry ent_reg: key length read settles
            S_ENT: st_next = S_CMP;
            // bytes 0..klen-1 compared one per cycle, data lags index by one
            S_CMP:
            begin
                if (!used_reg[ent_reg] || klen_rd != cmd.klen)
                    st_next = last_ent ? S_DEC : S_ENT;
                else if (k_reg != '0 && !eq_now)
                    st_next = last_ent ? S_DEC : S_ENT;
                else if (k_reg == (skv_pkg::VLW+1)'(cmd.klen) && eq_now)
                    st_next = S_DEC;
            end
            S_DEC:
            begin
                if (cmd.is_get)
                    st_next = match_reg ? S_OUT : S_MISS;
                else if (match_reg)
                    st_next = S_VCP;
                else if (have_free_reg)
                    st_next = S_KCP;
                else
                begin
                    cmd_pop = 1'b1;
                    st_next = S_IDLE;
                end
            end
            S_KCP: if (k_reg == (skv_pkg::VLW+1)'(cmd.klen)) st_next = S_VCP;
            S_VCP: if (k_reg == (skv_pkg::VLW+1)'(cmd.vlen))
                begin
                    cmd_pop = 1'b1;
                    st_next = S_IDLE;
                end
            S_OUT:
            begin
                if (k_reg != '0 && (!obuf_full_reg || out_ready))
                begin
                    emit = 1'b1;
                    emit_data = {1'b1, vt_rd};
                    emit_last = k_reg == n_reg;
                    if (emit_last)
                    begin
                        cmd_pop = 1'b1;
                        st_next = S_IDLE;
                    end
                end
            end
            S_MISS: if (!obuf_full_reg || out_ready)
                begin
                    emit = 1'b1;
                    cmd_pop = 1'b1;
                    st_next = S_IDLE;
                end
            default: st_next = S_IDLE;
        endcase
    end

    logic out_adv;
    assign out_adv = emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE; used_reg <= '0; ent_reg <= '0; free_reg <= '0;
            have_free_reg <= 1'b0; match_reg <= 1'b0; eq_reg <= 1'b1;
            k_reg <= '0; n_reg <= '0; obuf_full_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (emit) obuf_full_reg <= 1'b1;
            else if (out_ready) obuf_full_reg <= 1'b0;
            case (st_reg)
                S_IDLE:
                begin
                    ent_reg <= '0; match_reg <= 1'b0; have_free_reg <= 1'b0;
                    k_reg <= '0; eq_reg <= 1'b1;
                end
                S_ENT:
                begin
                    k_reg <= '0; eq_reg <= 1'b1;
                    if (!used_reg[ent_reg] && !have_free_reg)
                    begin
                        have_free_reg <= 1'b1;
                        free_reg <= ent_reg;
                    end
                end
                S_CMP:
                begin
                    eq_reg <= eq_now;
                    if (st_next == S_ENT)
                        ent_reg <= ent_reg + 1'b1;
                    else if (st_next == S_DEC)
                        match_reg <= used_reg[ent_reg] && klen_rd == cmd.klen &&
                                     (k_reg == (skv_pkg::VLW+1)'(cmd.klen)) && eq_now;
                    else
                        k_reg <= k_reg + 1'b1;
                end
                S_DEC:
                begin
                    k_reg <= '0;
                    n_reg <= (skv_pkg::VLW+1)'(vlen_rd);
                    if (!cmd.is_get && !match_reg && have_free_reg)
                        used_reg[free_reg] <= 1'b1;
                end
                S_KCP: k_reg <= (st_next == S_VCP) ? '0 : k_reg + 1'b1;
                S_VCP: k_reg <= k_reg + 1'b1;
                S_OUT: if (k_reg == '0 || emit) k_reg <= k_reg + 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv)
        begin
            odata_reg <= emit_data;
            olast_reg <= emit_last;
        end
    end

    `SKV_ASSERT_IMP(a_pop_has_cmd, clk, rst_n, cmd_pop, cmd_valid)
    `SKV_ASSERT_IMP(a_emit_room, clk, rst_n, emit, !obuf_full_reg || out_ready)
    `SKV_ASSERT_IMP(a_miss_zero, clk, rst_n, out_valid && !out_data[8], out_data[7:0] == 8'h00)
endmodule
`default_nettype wire

// ===== rtl/core/string_key_value_table_unit.sv =====
// top level of the text key/value table unit
// depends on skv_pkg, skv_front, skv_queue, skv_back
// the back starts a command once it is queued; the search visits each entry in turn, comparing
// key bytes on an entry of equal key length, over all ENTRIES unless one matches;
// then a new key copies key and value bytes into the table, an update the value bytes,
// and a hit answers one value byte per cycle while m_tready is high, a miss one zero byte
// throughput: one text byte per cycle while fewer than two commands are queued
// reset: asynchronous active low; clears the entry used bits and the parser at once
`default_nettype none
module string_key_value_table_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // data_byte
    input  wire logic       s_tuser,   // op
    input  wire logic       s_tlast,   // last_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // value_byte
    output logic            m_tuser,   // found
    output logic            m_tlast    // last
);
    logic cmd_valid, q_full, q_ne, pop, rd_sel;
    logic [skv_pkg::QW:0] q_cnt;
    skv_pkg::cmd_t cmd_in, cmd_out;
    logic [skv_pkg::KIW-1:0] kraddr;
    logic [skv_pkg::VIW-1:0] vraddr;
    logic [7:0] krdata, vrdata;
    logic [8:0] odata;
    logic buf_busy;

    // the front may only fill a bank that the back is not reading: with one queued
    // command the front owns the other bank, with two both banks are taken
    assign buf_busy = q_cnt >= (skv_pkg::QW+1)'(2);

    skv_front u_front (.clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .op(s_tuser), .data_byte(s_tdata), .last_byte(s_tlast), .cmd_valid(cmd_valid),
        .cmd(cmd_in), .q_full(q_full), .buf_busy(buf_busy), .rd_sel(rd_sel),
        .kraddr(kraddr), .krdata(krdata), .vraddr(vraddr), .vrdata(vrdata));

    skv_queue u_queue (.clk(clk), .rst_n(rst_n), .push(cmd_valid), .din(cmd_in),
        .pop(pop), .not_empty(q_ne), .full(q_full), .count(q_cnt), .dout(cmd_out));

    skv_back u_back (.clk(clk), .rst_n(rst_n), .cmd_valid(q_ne), .cmd(cmd_out),
        .cmd_pop(pop), .rd_sel(rd_sel), .kraddr(kraddr), .krdata(krdata),
        .vraddr(vraddr), .vrdata(vrdata), .out_valid(m_tvalid), .out_ready(m_tready),
        .out_data(odata), .out_last(m_tlast));

    // found flag on tuser, value byte on tdata
    assign m_tuser = odata[8];
    assign m_tdata = odata[7:0];
endmodule
`default_nettype wire
